// ===== hdl/srus_pkg.sv =====
// ----------------------------------------------------------------------------
// srus_pkg
// Shared types, constants and tables of the shadow register update scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package srus_pkg;

    localparam int NUM_REGS  = 25;
    localparam int NUM_PAIRS = 13;
    localparam int KIND_W    = 2;
    localparam int IDX_W     = 5;
    localparam int DATA_W    = 8;
    localparam int PTR_W     = 4;

    localparam logic [KIND_W-1:0] KIND_MERGE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DIRECT = 2'd2;

    // voice control registers whose gate bit holds back sustain/release
    localparam logic [IDX_W-1:0] REG_CTL_V0 = 5'd4;
    localparam logic [IDX_W-1:0] REG_CTL_V1 = 5'd11;
    localparam logic [IDX_W-1:0] REG_CTL_V2 = 5'd18;
    localparam logic [IDX_W-1:0] REG_SR_V0  = 5'd6;
    localparam logic [IDX_W-1:0] REG_SR_V1  = 5'd13;
    localparam logic [IDX_W-1:0] REG_SR_V2  = 5'd20;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,
        DP_MERGE,
        DP_DIRECT,
        DP_FIRST,
        DP_SECOND
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   pick_second;
    } t_dp_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              out_empty;
        logic              pair_sends;
    } t_dp_stat;

    // round-robin flush order, two registers per pair; the last pair names register 24 twice
    function automatic logic [IDX_W-1:0] pair_reg(input logic [PTR_W-1:0] p,
                                                  input logic second);
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        case (p)
            4'd0:    begin a = 5'd1;  b = 5'd0;  end
            4'd1:    begin a = 5'd3;  b = 5'd2;  end
            4'd2:    begin a = 5'd4;  b = 5'd5;  end
            4'd3:    begin a = 5'd6;  b = 5'd13; end
            4'd4:    begin a = 5'd8;  b = 5'd7;  end
            4'd5:    begin a = 5'd10; b = 5'd9;  end
            4'd6:    begin a = 5'd11; b = 5'd12; end
            4'd7:    begin a = 5'd15; b = 5'd14; end
            4'd8:    begin a = 5'd17; b = 5'd16; end
            4'd9:    begin a = 5'd18; b = 5'd19; end
            4'd10:   begin a = 5'd20; b = 5'd23; end
            4'd11:   begin a = 5'd22; b = 5'd21; end
            4'd12:   begin a = 5'd24; b = 5'd24; end
            default: begin a = 5'd1;  b = 5'd0;  end
        endcase
        return second ? b : a;
    endfunction

    function automatic logic [DATA_W-1:0] shadow_init(input logic [IDX_W-1:0] r);
        logic [DATA_W-1:0] v;
        case (r) inside
            [5'd21:5'd23]: v = 8'hFF;
            5'd24:         v = 8'h0F;
            default:       v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/srus_if.sv =====
// ----------------------------------------------------------------------------
// srus_in_if / srus_out_if
// Valid/ready channels for requests into and bus writes out of the scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

interface srus_in_if;
    logic                            valid;
    logic                            ready;
    logic [srus_pkg::KIND_W-1:0]     kind;
    logic [srus_pkg::IDX_W-1:0]      reg_index;
    logic [srus_pkg::DATA_W-1:0]     reg_data;
    logic [srus_pkg::DATA_W-1:0]     merge_mask;

    modport source (output valid, kind, reg_index, reg_data, merge_mask, input ready);
    modport sink   (input valid, kind, reg_index, reg_data, merge_mask, output ready);
endinterface

interface srus_out_if;
    logic                            valid;
    logic                            ready;
    logic [srus_pkg::IDX_W-1:0]      bus_index;
    logic [srus_pkg::DATA_W-1:0]     bus_data;
    logic                            last_write;

    modport source (output valid, bus_index, bus_data, last_write, input ready);
    modport sink   (input valid, bus_index, bus_data, last_write, output ready);
endinterface

`default_nettype wire

// ===== hdl/srus_ctrl.sv =====
// ----------------------------------------------------------------------------
// srus_ctrl
// Sequencer: takes a request, decodes its kind and steps the pair scan.
// ----------------------------------------------------------------------------
`default_nettype none

module srus_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire srus_pkg::t_dp_stat i_stat,
    output srus_pkg::t_dp_cmd      o_cmd
);
    import srus_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DIRECT,
        S_FIRST,
        S_SECOND
    } t_state;

    t_state           r_state, n_state;
    logic [PTR_W-1:0] r_cnt, n_cnt;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state           = r_state;
        n_cnt             = r_cnt;
        o_cmd.op          = DP_NOP;
        o_cmd.pick_second = (r_state == S_SECOND);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.kind)
                    KIND_MERGE: begin
                        o_cmd.op = DP_MERGE;
                        n_state  = S_IDLE;
                    end
                    KIND_FLUSH: begin
                        n_cnt   = '0;
                        n_state = S_FIRST;
                    end
                    KIND_DIRECT: n_state = S_DIRECT;
                    default:     n_state = S_IDLE;
                endcase
            end
            S_DIRECT: begin
                if (i_stat.out_empty) begin
                    o_cmd.op = DP_DIRECT;
                    n_state  = S_IDLE;
                end
            end
            S_FIRST: begin
                o_cmd.op = DP_FIRST;
                n_state  = S_SECOND;
            end
            S_SECOND: begin
                // results of a pair go out together, so wait for an empty queue
                if (!i_stat.pair_sends || i_stat.out_empty) begin
                    o_cmd.op = DP_SECOND;
                    if (i_stat.pair_sends || r_cnt == PTR_W'(NUM_PAIRS - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt   = r_cnt + 1'b1;
                        n_state = S_FIRST;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/srus_dp.sv =====
// ----------------------------------------------------------------------------
// srus_dp
// Shadow and sent register files, pair pointer and two-entry output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module srus_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire srus_pkg::t_dp_cmd             i_cmd,
    output srus_pkg::t_dp_stat                 o_stat,
    input  wire logic [srus_pkg::KIND_W-1:0]   i_kind,
    input  wire logic [srus_pkg::IDX_W-1:0]    i_reg_index,
    input  wire logic [srus_pkg::DATA_W-1:0]   i_reg_data,
    input  wire logic [srus_pkg::DATA_W-1:0]   i_merge_mask,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [srus_pkg::IDX_W-1:0]         o_bus_index,
    output logic [srus_pkg::DATA_W-1:0]        o_bus_data,
    output logic                               o_last_write
);
    import srus_pkg::*;

    logic [DATA_W-1:0] r_shadow [NUM_REGS];
    logic [DATA_W-1:0] r_sent   [NUM_REGS];
    logic [PTR_W-1:0]  r_ptr;
    logic              r_force;

    // latched request
    logic [KIND_W-1:0] r_kind;
    logic [IDX_W-1:0]  r_idx;
    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] r_mask;

    // first register of the current pair, held until the second is examined
    logic              r_hold_vld;
    logic [IDX_W-1:0]  r_hold_idx;
    logic [DATA_W-1:0] r_hold_data;

    logic [IDX_W-1:0]  r_q_idx  [2];
    logic [DATA_W-1:0] r_q_data [2];
    logic              r_q_last [2];
    logic [1:0]        r_q_cnt;

    logic [IDX_W-1:0]  w_cur;
    logic [DATA_W-1:0] w_cur_shadow;
    logic              w_cur_ok;
    logic              w_allowed;
    logic              w_send;
    logic              w_idx_ok;
    logic              w_pop;
    logic [PTR_W-1:0]  w_ptr_next;

    assign w_cur        = pair_reg(r_ptr, i_cmd.pick_second);
    assign w_cur_ok     = (w_cur < IDX_W'(NUM_REGS));
    assign w_cur_shadow = w_cur_ok ? r_shadow[w_cur] : '0;
    assign w_idx_ok     = (r_idx < IDX_W'(NUM_REGS));
    assign w_ptr_next   = (r_ptr == PTR_W'(NUM_PAIRS - 1)) ? '0 : r_ptr + 1'b1;

    always_comb begin
        case (w_cur)
            REG_SR_V0: w_allowed = !r_shadow[REG_CTL_V0][0];
            REG_SR_V1: w_allowed = !r_shadow[REG_CTL_V1][0];
            REG_SR_V2: w_allowed = !r_shadow[REG_CTL_V2][0];
            default:   w_allowed = 1'b1;
        endcase
    end

    assign w_send = w_cur_ok &&
                    (r_force || (w_allowed && (r_sent[w_cur] != w_cur_shadow)));

    assign o_stat.kind       = r_kind;
    assign o_stat.out_empty  = (r_q_cnt == 2'd0);
    assign o_stat.pair_sends = r_hold_vld || w_send;

    assign o_valid      = (r_q_cnt != 2'd0);
    assign o_bus_index  = r_q_idx[0];
    assign o_bus_data   = r_q_data[0];
    assign o_last_write = r_q_last[0];
    assign w_pop        = o_valid && i_ready;

    // register files and scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_shadow[i] <= shadow_init(IDX_W'(i));
                r_sent[i]   <= '0;
            end
            r_ptr      <= '0;
            r_force    <= 1'b1;
            r_hold_vld <= 1'b0;
        end else begin
            case (i_cmd.op)
                DP_MERGE: begin
                    if (w_idx_ok) begin
                        r_shadow[r_idx] <= (r_shadow[r_idx] & ~r_mask) | (r_data & r_mask);
                    end
                end
                DP_DIRECT: begin
                    if (w_idx_ok) begin
                        r_shadow[r_idx] <= r_data;
                        r_sent[r_idx]   <= r_data;
                    end
                end
                DP_FIRST: begin
                    if (w_send) begin
                        r_sent[w_cur] <= w_cur_shadow;
                    end
                    r_hold_vld  <= w_send;
                    r_hold_idx  <= w_cur;
                    r_hold_data <= w_cur_shadow;
                end
                DP_SECOND: begin
                    if (w_send) begin
                        r_sent[w_cur] <= w_cur_shadow;
                    end
                    r_hold_vld <= 1'b0;
                    r_ptr      <= w_ptr_next;
                    if (w_ptr_next == '0) begin
                        r_force <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_LOAD) begin
            r_kind <= i_kind;
            r_idx  <= i_reg_index;
            r_data <= i_reg_data;
            r_mask <= i_merge_mask;
        end
    end

    // output queue: filled only when empty, so a fill never meets a pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_cnt <= 2'd0;
        end else if (i_cmd.op == DP_DIRECT) begin
            r_q_idx[0]  <= r_idx;
            r_q_data[0] <= r_data;
            r_q_last[0] <= 1'b1;
            r_q_cnt     <= 2'd1;
        end else if (i_cmd.op == DP_SECOND && (r_hold_vld || w_send)) begin
            if (r_hold_vld) begin
                r_q_idx[0]  <= r_hold_idx;
                r_q_data[0] <= r_hold_data;
                r_q_last[0] <= !w_send;
                r_q_idx[1]  <= w_cur;
                r_q_data[1] <= w_cur_shadow;
                r_q_last[1] <= 1'b1;
                r_q_cnt     <= w_send ? 2'd2 : 2'd1;
            end else begin
                r_q_idx[0]  <= w_cur;
                r_q_data[0] <= w_cur_shadow;
                r_q_last[0] <= 1'b1;
                r_q_cnt     <= 2'd1;
            end
        end else if (w_pop) begin
            r_q_idx[0]  <= r_q_idx[1];
            r_q_data[0] <= r_q_data[1];
            r_q_last[0] <= r_q_last[1];
            r_q_cnt     <= r_q_cnt - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/shadow_register_update_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// shadow_register_update_scheduler_top
// Flushes changed sound-chip registers from a shadow copy in round-robin pairs.
// ----------------------------------------------------------------------------
// One request is handled at a time. A request is taken in one cycle and decoded
// in the next; a masked shadow write then finishes, an immediate write goes out
// as soon as the output queue is empty, and a flush examines one register per
// cycle through the single register-file read path, first then second of each
// pair, stopping after the first pair that sends or after all 13 pairs; a pair
// that sends also waits for the output queue to drain first.
// Bus writes leave through a two-entry queue, so a new request is
// taken while earlier writes still wait on the bus side.
`default_nettype none

module shadow_register_update_scheduler_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    srus_in_if.sink    i_item,
    srus_out_if.source o_result
);
    import srus_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;

    assign i_item.ready = w_in_ready;

    srus_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    srus_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_kind       (i_item.kind),
        .i_reg_index  (i_item.reg_index),
        .i_reg_data   (i_item.reg_data),
        .i_merge_mask (i_item.merge_mask),
        .o_valid      (o_result.valid),
        .i_ready      (o_result.ready),
        .o_bus_index  (o_result.bus_index),
        .o_bus_data   (o_result.bus_data),
        .o_last_write (o_result.last_write)
    );

endmodule

`default_nettype wire

// ===== hdl/srus_checker.sv =====
// ----------------------------------------------------------------------------
// srus_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module srus_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_out_last
);

    // a held bus write stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("bus write dropped while stalled");

    // a taken request keeps the block busy for at least the decode cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken back to back");

    // a non-final write of a pair is followed straight away by the final one
    a_pair_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> i_out_valid && i_out_last)
        else $error("pair write without its final write");

    // out of reset the block is idle with nothing queued
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready && !i_out_valid)
        else $error("not idle after reset");

endmodule

bind shadow_register_update_scheduler_top srus_checker u_srus_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_last  (o_result.last_write)
);

`default_nettype wire
